/* hw/rtl/cld_pkg.sv */
`timescale 1ns / 1ps
package cld_pkg;

  localparam int PENDING_DEPTH = 32;
  localparam int RAW_DELIM_MAX = 16;
  localparam int CLOSE_MAX     = RAW_DELIM_MAX + 2;
  localparam int PEND_AW       = $clog2(PENDING_DEPTH);
  localparam int PEND_CW       = $clog2(PENDING_DEPTH + 1);
  localparam int CLOSE_AW      = $clog2(CLOSE_MAX);
  localparam int CLOSE_W       = $clog2(CLOSE_MAX + 1);
  localparam int CP_W          = 21;
  localparam int IN_TDATA_W    = 24;
  localparam int OUT_TDATA_W   = 24;

  typedef logic [CP_W-1:0] cp_t;

  localparam cp_t CH_LF     = cp_t'(10);
  localparam cp_t CH_CR     = cp_t'(13);
  localparam cp_t CH_SPACE  = cp_t'(32);
  localparam cp_t CH_QUOTE  = cp_t'(34);
  localparam cp_t CH_LPAREN = cp_t'(40);
  localparam cp_t CH_RPAREN = cp_t'(41);
  localparam cp_t CH_COMMA  = cp_t'(44);
  localparam cp_t CH_SEMI   = cp_t'(59);
  localparam cp_t CH_BSLASH = cp_t'(92);
  localparam cp_t CH_RBRACE = cp_t'(125);
  localparam cp_t CH_CAP_R  = cp_t'(82);
  localparam cp_t CH_PARA   = cp_t'(32'h2029);
  localparam cp_t CP_MAX    = cp_t'(32'h10FFFF);

  // commands to the raw-string window unit
  typedef struct packed {
    logic clear;
    logic start;
    logic append;
    logic push;
    logic shift;
    logic fill_clr;
    cp_t  data;
  } raw_cmd_t;

  typedef struct packed {
    logic [CLOSE_W-1:0] close_len;
    logic [CLOSE_W-1:0] fill;
    logic               match;
    cp_t                head;
  } raw_stat_t;

  typedef struct packed {
    logic push_v;
    cp_t  push_c;
    logic fin_v;
    logic fin_done;
    logic ovf;
  } emit_req_t;

  typedef struct packed {
    logic push_rdy;
    logic fin_rdy;
  } emit_rdy_t;

endpackage

/* hw/rtl/cld_ram.sv */
`timescale 1ns / 1ps
module cld_ram #(
  parameter int W  = 21,
  parameter int D  = 32,
  parameter int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* hw/rtl/cld_raw.sv */
`timescale 1ns / 1ps
module cld_raw (
  input  logic                clk,
  input  logic                rst_n,
  input  cld_pkg::raw_cmd_t   cmd,
  output cld_pkg::raw_stat_t  st
);
  import cld_pkg::*;

  cp_t                cs_r  [CLOSE_MAX];
  cp_t                win_r [CLOSE_MAX];
  logic [CLOSE_W-1:0] cl_r;
  logic [CLOSE_W-1:0] fill_r;
  logic               room;
  logic               match;

  assign room = cl_r < CLOSE_W'(CLOSE_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cl_r   <= '0;
      fill_r <= '0;
    end else if (cmd.clear) begin
      cl_r   <= '0;
      fill_r <= '0;
    end else begin
      if (cmd.start) begin
        cl_r <= CLOSE_W'(1);
      end
      if (cmd.append && room) begin
        cl_r <= cl_r + CLOSE_W'(1);
      end
      if (cmd.push) begin
        fill_r <= fill_r + CLOSE_W'(1);
      end
      if (cmd.shift) begin
        fill_r <= fill_r - CLOSE_W'(1);
      end
      if (cmd.fill_clr) begin
        fill_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cs_r[0] <= CH_RPAREN;
    end
    if (cmd.append && room) begin
      cs_r[cl_r[CLOSE_AW-1:0]] <= cmd.data;
    end
    if (cmd.push && fill_r < CLOSE_W'(CLOSE_MAX)) begin
      win_r[fill_r[CLOSE_AW-1:0]] <= cmd.data;
    end
    if (cmd.shift) begin
      for (int i = 0; i < CLOSE_MAX - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
    end
  end

  // window against closing sequence, one comparator per entry
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CLOSE_MAX; i++) begin
      if (CLOSE_W'(i) < cl_r && win_r[i] != cs_r[i]) begin
        match = 1'b0;
      end
    end
  end

  assign st.close_len = cl_r;
  assign st.fill      = fill_r;
  assign st.match     = match;
  assign st.head      = win_r[0];

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CLOSE_W'(CLOSE_MAX)) else $error("raw window overfilled");
  a_cl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cl_r <= CLOSE_W'(CLOSE_MAX)) else $error("closing sequence overlong");
  a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift && !cmd.clear |-> fill_r != '0) else $error("shift of empty window");
endmodule

/* hw/rtl/cld_emit.sv */
`timescale 1ns / 1ps
module cld_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cld_pkg::emit_req_t            req,
  output cld_pkg::emit_rdy_t            rdy,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [cld_pkg::OUT_TDATA_W-1:0] out_tdata, // out_char, text_done, overflow, zero pad
  output logic                          out_tuser,   // has_char
  output logic                          out_tlast    // last_of_run
);
  import cld_pkg::*;

  logic ov_r;
  logic held_v_r;
  cp_t  held_c_r;
  cp_t  o_char_r;
  logic o_has_r;
  logic o_last_r;
  logic o_done_r;
  logic o_ovf_r;
  logic out_free;
  logic push_acc;
  logic fin_acc;

  assign out_free     = !ov_r || out_tready;
  assign rdy.push_rdy = !held_v_r || out_free;
  assign rdy.fin_rdy  = (held_v_r || req.fin_done) ? out_free : 1'b1;
  assign push_acc     = req.push_v && rdy.push_rdy;
  assign fin_acc      = req.fin_v && rdy.fin_rdy;

  // one character is held back so the last beat of an item can carry tlast
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r     <= 1'b0;
      held_v_r <= 1'b0;
    end else begin
      if (out_tready) begin
        ov_r <= 1'b0;
      end
      if (push_acc) begin
        held_v_r <= 1'b1;
        if (held_v_r) begin
          ov_r <= 1'b1;
        end
      end else if (fin_acc) begin
        held_v_r <= 1'b0;
        if (held_v_r || req.fin_done) begin
          ov_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_acc) begin
      held_c_r <= req.push_c;
      if (held_v_r) begin
        o_char_r <= held_c_r;
        o_has_r  <= 1'b1;
        o_last_r <= 1'b0;
        o_done_r <= 1'b0;
        o_ovf_r  <= req.ovf;
      end
    end else if (fin_acc && (held_v_r || req.fin_done)) begin
      o_char_r <= held_v_r ? held_c_r : '0;
      o_has_r  <= held_v_r;
      o_last_r <= 1'b1;
      o_done_r <= req.fin_done;
      o_ovf_r  <= req.ovf;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {{(OUT_TDATA_W - CP_W - 2){1'b0}}, o_ovf_r, o_done_r, o_char_r};
  assign out_tuser  = o_has_r;
  assign out_tlast  = o_last_r;

  a_no_dual: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.push_v && req.fin_v)) else $error("push and finish together");
  a_fin_empties: assert property (@(posedge clk) disable iff (!rst_n)
    fin_acc |=> !held_v_r) else $error("held char survived finish");
  a_bare_done: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !o_has_r |-> o_done_r && o_last_r) else $error("bare beat not end marker");
endmodule

/* hw/rtl/c_string_literal_decoder.sv */
`timescale 1ns / 1ps
// one item in flight: the next beat is accepted only once the current one has passed through
// S_DECODE, S_DUMP_RD, S_PUT1, S_PUT2, S_KEEP and S_FINISH back to S_IDLE
// each character dumped from the pending buffer ram is read in S_DUMP_RD and pushed in S_DUMP_WR (registered read)
// a raw body character passes S_DECODE, S_RAW_CMP and S_FINISH; an end marker may first dump the buffered
// characters or flush the raw window; out_tready low stalls the push and finish states
// synchronous active-low reset clears control state; buffer and window contents need none
module c_string_literal_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [cld_pkg::IN_TDATA_W-1:0]  in_tdata,   // code_point, zero pad
  input  logic                            in_tlast,   // end_of_text
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [cld_pkg::OUT_TDATA_W-1:0] out_tdata,  // out_char, text_done, overflow, zero pad
  output logic                            out_tuser,  // has_char
  output logic                            out_tlast   // last_of_run
);
  import cld_pkg::*;

  typedef enum logic [3:0] {
    M_SPACE, M_TRAIL, M_PREFIX, M_INSIDE, M_SLASH, M_OCT, M_HEX,
    M_SUFFIX, M_OUTSIDE, M_RAWDELIM, M_RAWBODY
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_DUMP_RD, S_DUMP_WR, S_PUT1, S_PUT2,
    S_RAW_CMP, S_RAW_FLUSH, S_KEEP, S_FINISH
  } state_t;

  state_t             state_r, state_nxt;
  mode_t              mode_r, mode_nxt;
  logic [PEND_CW-1:0] pend_cnt_r, pend_cnt_nxt;
  logic               prev_cr_r, prev_cr_nxt;
  logic               prev_r_r, prev_r_nxt;
  logic [31:0]        esc_r, esc_nxt;
  logic [3:0]         dl_r, dl_nxt;
  logic               ovf_r, ovf_nxt;
  cp_t                in_c_r, in_c_nxt;
  logic               eot_r, eot_nxt;
  cp_t                ch_r, ch_nxt;
  logic [PEND_CW-1:0] dump_len_r, dump_len_nxt;
  logic [PEND_CW-1:0] rd_idx_r, rd_idx_nxt;
  logic               put1_v_r, put1_v_nxt;
  cp_t                put1_r, put1_nxt;
  logic               put2_v_r, put2_v_nxt;
  cp_t                put2_r, put2_nxt;
  logic               keep_v_r, keep_v_nxt;
  logic [PEND_AW-1:0] keep_idx_r, keep_idx_nxt;
  logic               done_r, done_nxt;

  raw_cmd_t  raw_cmd;
  raw_stat_t raw_st;
  emit_req_t ereq;
  emit_rdy_t erdy;
  logic      mem_re;
  cp_t       mem_rdata;

  function automatic logic is_alpha(cp_t c);
    return (c >= cp_t'(97) && c <= cp_t'(122)) || (c >= cp_t'(65) && c <= cp_t'(90)) ||
           c == cp_t'(95);
  endfunction

  function automatic logic is_digit(cp_t c);
    return c >= cp_t'(48) && c <= cp_t'(57);
  endfunction

  function automatic logic is_sep(cp_t c);
    return c == CH_COMMA || c == CH_SEMI || c == CH_RPAREN || c == CH_RBRACE;
  endfunction

  // 31 marks a non-digit
  function automatic logic [4:0] digit_val(cp_t c);
    logic [4:0] v;
    v = 5'd31;
    if (is_digit(c)) v = 5'(c - cp_t'(48));
    else if (c >= cp_t'(65) && c <= cp_t'(70)) v = 5'(c - cp_t'(55));
    else if (c >= cp_t'(97) && c <= cp_t'(102)) v = 5'(c - cp_t'(87));
    return v;
  endfunction

  // {valid, char}: drops zero, surrogates and codes beyond unicode, maps 13 to line feed
  function automatic logic [CP_W:0] code_out(logic [31:0] v);
    logic [CP_W:0] r;
    r = '0;
    if (v < 32'hD800) begin
      if (v == 32'd13) r = {1'b1, CH_LF};
      else if (v != 32'd0) r = {1'b1, v[CP_W-1:0]};
    end else if (v >= 32'hE000 && v <= 32'h10FFFF) begin
      r = {1'b1, v[CP_W-1:0]};
    end
    return r;
  endfunction

  cld_ram #(.W(CP_W), .D(PENDING_DEPTH)) u_pend (
    .clk   (clk),
    .we    (state_r == S_KEEP && keep_v_r),
    .waddr (keep_idx_r),
    .wdata (ch_r),
    .re    (mem_re),
    .raddr (rd_idx_r[PEND_AW-1:0]),
    .rdata (mem_rdata)
  );

  cld_raw u_raw (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (raw_cmd),
    .st    (raw_st)
  );

  cld_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (ereq),
    .rdy        (erdy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  assign in_tready = state_r == S_IDLE;

  always_comb begin
    cp_t                ch;
    logic               blank;
    logic               do_dump;
    logic               do_clear;
    logic               do_keep;
    logic [PEND_CW-1:0] cnt_after;
    logic [4:0]         dv;
    logic               dig_ok;
    logic [31:0]        ev_new;
    logic [3:0]         dl_new;
    logic [CP_W:0]      cv;

    state_nxt    = state_r;
    mode_nxt     = mode_r;
    pend_cnt_nxt = pend_cnt_r;
    prev_cr_nxt  = prev_cr_r;
    prev_r_nxt   = prev_r_r;
    esc_nxt      = esc_r;
    dl_nxt       = dl_r;
    ovf_nxt      = ovf_r;
    in_c_nxt     = in_c_r;
    eot_nxt      = eot_r;
    ch_nxt       = ch_r;
    dump_len_nxt = dump_len_r;
    rd_idx_nxt   = rd_idx_r;
    put1_v_nxt   = put1_v_r;
    put1_nxt     = put1_r;
    put2_v_nxt   = put2_v_r;
    put2_nxt     = put2_r;
    keep_v_nxt   = keep_v_r;
    keep_idx_nxt = keep_idx_r;
    done_nxt     = done_r;
    raw_cmd      = '0;
    ereq         = '0;
    ereq.ovf     = ovf_r;
    mem_re       = 1'b0;
    ch           = in_c_r;
    blank        = 1'b0;
    do_dump      = 1'b0;
    do_clear     = 1'b0;
    do_keep      = 1'b0;
    cnt_after    = pend_cnt_r;
    dv           = '0;
    dig_ok       = 1'b0;
    ev_new       = '0;
    dl_new       = '0;
    cv           = '0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          in_c_nxt  = in_tdata[CP_W-1:0];
          eot_nxt   = in_tlast;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        rd_idx_nxt   = '0;
        dump_len_nxt = '0;
        put1_v_nxt   = 1'b0;
        put2_v_nxt   = 1'b0;
        keep_v_nxt   = 1'b0;
        done_nxt     = eot_r;
        state_nxt    = S_DUMP_RD;
        if (eot_r) begin
          if (mode_r == M_SPACE || mode_r == M_PREFIX) begin
            dump_len_nxt = pend_cnt_r;
          end
          if ((mode_r == M_OCT || mode_r == M_HEX) && dl_r != '0) begin
            cv         = code_out(esc_r);
            put1_v_nxt = cv[CP_W];
            put1_nxt   = cv[CP_W-1:0];
          end
          if (mode_r == M_RAWBODY) begin
            state_nxt = S_RAW_FLUSH;
          end
          mode_nxt     = M_SPACE;
          pend_cnt_nxt = '0;
          prev_cr_nxt  = 1'b0;
          prev_r_nxt   = 1'b0;
          esc_nxt      = '0;
          dl_nxt       = '0;
        end else if (in_c_r > CP_MAX) begin
          state_nxt = S_IDLE;
        end else if (prev_cr_r && in_c_r == CH_LF) begin
          prev_cr_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end else begin
          prev_cr_nxt = in_c_r == CH_CR;
          if (in_c_r == CH_CR || in_c_r == CH_PARA) ch = CH_LF;
          ch_nxt     = ch;
          prev_r_nxt = ch == CH_CAP_R;
          blank      = ch == CH_SPACE || ch == CH_LF;
          put1_nxt   = ch;
          put2_nxt   = ch;
          case (mode_r)
            M_PREFIX: begin
              if (blank) begin
                do_dump  = 1'b1;
                do_keep  = 1'b1;
                mode_nxt = M_SPACE;
              end else if (ch == CH_QUOTE) begin
                do_clear = 1'b1;
                if (prev_r_r) begin
                  raw_cmd.start = 1'b1;
                  mode_nxt      = M_RAWDELIM;
                end else begin
                  mode_nxt = M_INSIDE;
                end
              end else if (is_alpha(ch) || is_digit(ch)) begin
                do_keep = 1'b1;
              end else begin
                do_dump    = 1'b1;
                put1_v_nxt = 1'b1;
                mode_nxt   = M_OUTSIDE;
              end
            end
            M_OUTSIDE: begin
              if (blank) begin
                do_clear = 1'b1;
                do_keep  = 1'b1;
                mode_nxt = M_SPACE;
              end else if (ch == CH_QUOTE) begin
                mode_nxt = M_INSIDE;
              end else if (is_alpha(ch)) begin
                do_clear = 1'b1;
                do_keep  = 1'b1;
                mode_nxt = M_PREFIX;
              end else begin
                put1_v_nxt = 1'b1;
              end
            end
            M_INSIDE: begin
              if (ch == CH_QUOTE) mode_nxt = M_SUFFIX;
              else if (ch == CH_BSLASH) mode_nxt = M_SLASH;
              else put1_v_nxt = 1'b1;
            end
            M_SLASH: begin
              mode_nxt   = M_INSIDE;
              put1_v_nxt = 1'b1;
              case (ch)
                cp_t'(97):  put1_nxt = cp_t'(7);
                cp_t'(98):  put1_nxt = cp_t'(8);
                cp_t'(116): put1_nxt = cp_t'(9);
                cp_t'(110), cp_t'(114): put1_nxt = CH_LF;
                cp_t'(102): put1_nxt = cp_t'(12);
                cp_t'(118): put1_nxt = cp_t'(11);
                cp_t'(85), cp_t'(117), cp_t'(120): begin
                  put1_v_nxt = 1'b0;
                  esc_nxt    = '0;
                  mode_nxt   = M_HEX;
                  dl_nxt     = (ch == cp_t'(85)) ? 4'd8 : (ch == cp_t'(117)) ? 4'd4 : 4'd2;
                end
                CH_LF: put1_v_nxt = 1'b0;
                default: begin
                  if (ch >= cp_t'(48) && ch <= cp_t'(55)) begin
                    put1_v_nxt = 1'b0;
                    esc_nxt    = 32'(ch - cp_t'(48));
                    dl_nxt     = 4'd2;
                    mode_nxt   = M_OCT;
                  end
                end
              endcase
            end
            M_OCT, M_HEX: begin
              dv = digit_val(ch);
              if (mode_r == M_OCT) begin
                dig_ok = dv < 5'd8;
                ev_new = {esc_r[28:0], 3'b000} | 32'(dv);
              end else begin
                dig_ok = dv < 5'd16;
                ev_new = {esc_r[27:0], 4'b0000} | 32'(dv);
              end
              dl_new = (dl_r != '0) ? dl_r - 4'd1 : dl_r;
              if (dig_ok && dl_new != '0) begin
                esc_nxt = ev_new;
                dl_nxt  = dl_new;
              end else begin
                cv         = code_out(dig_ok ? ev_new : esc_r);
                put1_v_nxt = cv[CP_W];
                put1_nxt   = cv[CP_W-1:0];
                put2_v_nxt = !dig_ok;
                mode_nxt   = M_INSIDE;
                esc_nxt    = '0;
                dl_nxt     = '0;
              end
            end
            M_SUFFIX: begin
              if (blank || is_sep(ch)) begin
                do_clear = 1'b1;
                do_keep  = 1'b1;
                mode_nxt = M_TRAIL;
              end else if (!(is_alpha(ch) || is_digit(ch))) begin
                put1_v_nxt = 1'b1;
                mode_nxt   = M_OUTSIDE;
              end
            end
            M_RAWDELIM: begin
              raw_cmd.data = ch;
              if (ch == CH_LPAREN || ch == CH_RPAREN) begin
                raw_cmd.append   = 1'b1;
                raw_cmd.data     = CH_QUOTE;
                raw_cmd.fill_clr = 1'b1;
                mode_nxt         = M_RAWBODY;
              end else if (raw_st.close_len < CLOSE_W'(RAW_DELIM_MAX + 1)) begin
                raw_cmd.append = 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            M_RAWBODY: begin
              raw_cmd.push = 1'b1;
              raw_cmd.data = ch;
              state_nxt    = S_RAW_CMP;
            end
            default: begin
              if (blank) begin
                do_keep = 1'b1;
              end else if (ch == CH_QUOTE) begin
                do_clear = 1'b1;
                mode_nxt = M_INSIDE;
              end else if (is_sep(ch) && mode_r == M_TRAIL) begin
                do_keep = 1'b1;
              end else if (is_alpha(ch)) begin
                do_keep  = 1'b1;
                mode_nxt = M_PREFIX;
              end else begin
                if (mode_r == M_TRAIL) do_clear = 1'b1;
                else do_dump = 1'b1;
                put1_v_nxt = 1'b1;
                mode_nxt   = M_OUTSIDE;
              end
            end
          endcase
          if (do_dump) dump_len_nxt = pend_cnt_r;
          if (do_dump || do_clear) cnt_after = '0;
          pend_cnt_nxt = cnt_after;
          if (do_keep) begin
            if (cnt_after < PEND_CW'(PENDING_DEPTH)) begin
              keep_v_nxt   = 1'b1;
              keep_idx_nxt = cnt_after[PEND_AW-1:0];
              pend_cnt_nxt = cnt_after + PEND_CW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
      end

      S_DUMP_RD: begin
        if (rd_idx_r == dump_len_r) begin
          state_nxt = S_PUT1;
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_DUMP_WR;
        end
      end

      S_DUMP_WR: begin
        ereq.push_v = 1'b1;
        ereq.push_c = mem_rdata;
        if (erdy.push_rdy) begin
          rd_idx_nxt = rd_idx_r + PEND_CW'(1);
          state_nxt  = S_DUMP_RD;
        end
      end

      S_PUT1: begin
        ereq.push_v = put1_v_r;
        ereq.push_c = put1_r;
        if (!put1_v_r || erdy.push_rdy) state_nxt = S_PUT2;
      end

      S_PUT2: begin
        ereq.push_v = put2_v_r;
        ereq.push_c = put2_r;
        if (!put2_v_r || erdy.push_rdy) state_nxt = S_KEEP;
      end

      S_KEEP: begin
        state_nxt = S_FINISH;
      end

      S_RAW_CMP: begin
        if (raw_st.fill < raw_st.close_len) begin
          state_nxt = S_FINISH;
        end else if (raw_st.match) begin
          raw_cmd.fill_clr = 1'b1;
          mode_nxt         = M_SUFFIX;
          state_nxt        = S_FINISH;
        end else begin
          // oldest window char can no longer start the closing sequence
          ereq.push_v = 1'b1;
          ereq.push_c = raw_st.head;
          if (erdy.push_rdy) begin
            raw_cmd.shift = 1'b1;
            state_nxt     = S_FINISH;
          end
        end
      end

      S_RAW_FLUSH: begin
        if (raw_st.fill == '0) begin
          state_nxt = S_FINISH;
        end else begin
          ereq.push_v = 1'b1;
          ereq.push_c = raw_st.head;
          if (erdy.push_rdy) raw_cmd.shift = 1'b1;
        end
      end

      S_FINISH: begin
        ereq.fin_v    = 1'b1;
        ereq.fin_done = done_r;
        if (erdy.fin_rdy) begin
          raw_cmd.clear = done_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      mode_r     <= M_SPACE;
      pend_cnt_r <= '0;
      prev_cr_r  <= 1'b0;
      prev_r_r   <= 1'b0;
      esc_r      <= '0;
      dl_r       <= '0;
      ovf_r      <= 1'b0;
      put1_v_r   <= 1'b0;
      put2_v_r   <= 1'b0;
      keep_v_r   <= 1'b0;
      done_r     <= 1'b0;
      rd_idx_r   <= '0;
      dump_len_r <= '0;
    end else begin
      state_r    <= state_nxt;
      mode_r     <= mode_nxt;
      pend_cnt_r <= pend_cnt_nxt;
      prev_cr_r  <= prev_cr_nxt;
      prev_r_r   <= prev_r_nxt;
      esc_r      <= esc_nxt;
      dl_r       <= dl_nxt;
      ovf_r      <= ovf_nxt;
      put1_v_r   <= put1_v_nxt;
      put2_v_r   <= put2_v_nxt;
      keep_v_r   <= keep_v_nxt;
      done_r     <= done_nxt;
      rd_idx_r   <= rd_idx_nxt;
      dump_len_r <= dump_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_c_r     <= in_c_nxt;
    eot_r      <= eot_nxt;
    ch_r       <= ch_nxt;
    put1_r     <= put1_nxt;
    put2_r     <= put2_nxt;
    keep_idx_r <= keep_idx_nxt;
  end

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r) else $error("overflow flag cleared");
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_cnt_r <= PEND_CW'(PENDING_DEPTH)) else $error("pending count overrun");
  a_code_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_OCT || mode_r == M_HEX) |-> dl_r != '0) else $error("code with no digits left");
  a_raw_cmp_fill: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RAW_CMP |-> raw_st.fill <= raw_st.close_len) else $error("window beyond close");
endmodule
